[sv/mavg_pkg.sv]
// mavg_pkg: shared widths, register indexes and status types of the moving average filter
// depends on nothing; imported by every other module of the block but mavg_ram

package mavg_pkg;

	// field and state widths
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_WINDOW  = 256;
	localparam int ADDR_BITS   = 8;
	localparam int CNT_BITS    = 9;
	localparam int SUM_BITS    = 25;
	localparam int WSUM_BITS   = 33;
	localparam int FRAC_BITS   = 8;
	localparam int OUT_BITS    = 24;

	// serial multiplier: 9-bit multiplier, multiplicand wide enough for n * sample
	localparam int MUL_BITS     = CNT_BITS;
	localparam int MCAND_BITS   = SUM_BITS;
	localparam int MUL_CNT_BITS = 4;

	// serial divider: signed dividend, its magnitude and a 16-bit divisor
	localparam int DVDS_BITS    = WSUM_BITS + FRAC_BITS;
	localparam int DVD_BITS     = DVDS_BITS - 1;
	localparam int DIVR_BITS    = 16;
	localparam int DIV_CNT_BITS = 6;

	// configuration port
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic REG_WINDOW  = 1'b0;
	localparam logic REG_MODE    = 1'b1;
	localparam logic [CNT_BITS-1:0] WINDOW_RESET = 9'd16;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

[sv/mavg_ram.sv]
// mavg_ram: generic simple dual-port RAM, one write and one registered read port
// read-first on an address collision; no package dependency

module mavg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// storage and registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

[sv/mavg_mul.sv]
// mavg_mul: bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on mavg_pkg

module mavg_mul (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [mavg_pkg::MUL_BITS-1:0]            m,
	input  logic signed [mavg_pkg::MCAND_BITS-1:0]   mcand,
	output mavg_pkg::unit_sts_t                      sts,
	output logic signed [mavg_pkg::MCAND_BITS-1:0]   prod
);

	import mavg_pkg::*;

	logic [MUL_BITS-1:0]          m_q;
	logic signed [MCAND_BITS-1:0] mc_q;
	logic signed [MCAND_BITS-1:0] acc_q;
	logic [MUL_CNT_BITS-1:0]      cnt_q;
	logic                         done_q;

	// load, then add the shifted multiplicand for each set multiplier bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == MUL_CNT_BITS'(1));
			if (start) begin
				cnt_q <= MUL_CNT_BITS'(MUL_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - MUL_CNT_BITS'(1);
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			m_q   <= m;
			mc_q  <= mcand;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			if (m_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= mc_q <<< 1;
			m_q  <= m_q >> 1;
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;
	assign prod     = acc_q;

endmodule

[sv/mavg_div.sv]
// mavg_div: bit-serial restoring divider, one quotient bit per cycle, truncating toward zero
// depends on mavg_pkg

module mavg_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [mavg_pkg::DVDS_BITS-1:0]  dividend,
	input  logic [mavg_pkg::DIVR_BITS-1:0]         divisor,
	output mavg_pkg::unit_sts_t                    sts,
	output logic [mavg_pkg::OUT_BITS-1:0]          quotient
);

	import mavg_pkg::*;

	logic [DVD_BITS-1:0]     dv_q;
	logic [DIVR_BITS-1:0]    rem_q;
	logic [DIVR_BITS-1:0]    dsr_q;
	logic                    neg_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    done_q;
	logic [DVDS_BITS-1:0]    mag;
	logic [DIVR_BITS+1:0]    part;
	logic [DIVR_BITS+1:0]    diff;

	// magnitude of the dividend and the trial subtraction
	always_comb begin
		mag  = dividend[DVDS_BITS-1] ? DVDS_BITS'(-dividend) : DVDS_BITS'(dividend);
		part = {1'b0, rem_q, dv_q[DVD_BITS-1]};
		diff = part - {2'b00, dsr_q};
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DIV_CNT_BITS'(1));
			if (start) begin
				cnt_q <= DIV_CNT_BITS'(DVD_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_CNT_BITS'(1);
			end
		end
	end

	// shift the dividend out at the top and the quotient in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dv_q  <= mag[DVD_BITS-1:0];
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= dividend[DVDS_BITS-1];
		end else if (cnt_q != '0) begin
			rem_q <= diff[DIVR_BITS+1] ? part[DIVR_BITS-1:0] : diff[DIVR_BITS-1:0];
			dv_q  <= {dv_q[DVD_BITS-2:0], ~diff[DIVR_BITS+1]};
		end
	end

	// restore the sign
	assign quotient = neg_q ? (~dv_q[OUT_BITS-1:0] + OUT_BITS'(1)) : dv_q[OUT_BITS-1:0];
	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;

endmodule

[sv/moving_average_filter.sv]
// moving_average_filter: plain and linearly weighted moving average over a sample stream
// depends on mavg_pkg, mavg_ram, mavg_mul and mavg_div
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+--------------------------------------
//  s_*      | in  | s_tvalid / s_tready     | tdata: sample[15:0]; tuser: start_req
//  m_*      | out | m_tvalid / m_tready     | tdata: average[23:0] (signed Q15.8)
//  apb      | in  | psel/penable, pready=1  | 0x0 window_length, 0x4 weighted_mode
//
// one transaction at a time; the sums are updated incrementally from the delay line
// a plain-mode transaction after a start request passes through the 40-step serial divider;
// a growing window adds the serial n * sample multiply and a sliding one also drops the
// oldest sample first, weighted mode adds another multiply for the n(n+1)/2 divisor,
// and a window that shrinks or jumps forces a rescan of the delay line
// the result waits in an output register, so a stalled m_tready does not block the next
// input until that register is needed again; reset clears the control state and the sums

module moving_average_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [mavg_pkg::SAMPLE_BITS-1:0]      s_tdata,  // [15:0] sample
	input  logic [0:0]                            s_tuser,  // [0] start_req
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [mavg_pkg::OUT_BITS-1:0]         m_tdata,  // [23:0] average
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [mavg_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  logic [mavg_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [mavg_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                  pready
);

	import mavg_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_OLD  = 7'b0000010,
		ST_SCAN = 7'b0000100,
		ST_PREP = 7'b0001000,
		ST_MUL  = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t                        state_q;
	logic [CNT_BITS-1:0]           window_q;
	logic                          mode_q;
	logic [CNT_BITS-1:0]           fill_q;
	logic [ADDR_BITS-1:0]          wp_q;
	logic [CNT_BITS-1:0]           n_q;
	logic signed [SUM_BITS-1:0]    sum_q;
	logic signed [WSUM_BITS-1:0]   wsum_q;
	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic [ADDR_BITS-1:0]          addr_q;
	logic [CNT_BITS-1:0]           left_q;
	logic                          rd_valid_q;
	logic                          tri_q;
	logic                          out_valid_q;
	logic [OUT_BITS-1:0]           out_data_q;

	logic                          accept;
	logic                          cfg_wr;
	logic                          is_start;
	logic                          is_ramp;
	logic                          is_slide;
	logic [CNT_BITS-1:0]           fill_new;
	logic [ADDR_BITS-1:0]          wp_new;
	logic [CNT_BITS-1:0]           n_new;
	logic signed [SAMPLE_BITS-1:0] in_sample;
	logic [SAMPLE_BITS-1:0]        rd_data;
	logic signed [SAMPLE_BITS-1:0] rd_sample;
	logic [ADDR_BITS-1:0]          raddr;
	logic signed [SUM_BITS-1:0]    scan_sum;
	logic [CNT_BITS-1:0]           win_wr;

	logic                          mul_start;
	logic [MUL_BITS-1:0]           mul_m;
	logic signed [MCAND_BITS-1:0]  mul_mcand;
	logic signed [MCAND_BITS-1:0]  mul_prod;
	unit_sts_t                     mul_sts;
	logic                          div_start;
	logic signed [DVDS_BITS-1:0]   div_dividend;
	logic [DIVR_BITS-1:0]          div_divisor;
	logic [OUT_BITS-1:0]           div_quot;
	unit_sts_t                     div_sts;

	// handshakes
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign pready    = 1'b1;
	assign cfg_wr    = psel & penable & pwrite & pready;
	assign in_sample = s_tdata;
	assign rd_sample = rd_data;

	// register read-back
	assign prdata = (paddr[2] == REG_MODE) ? APB_DATA_BITS'(mode_q) : APB_DATA_BITS'(window_q);

	// window clamp on write
	always_comb begin
		if (pwdata == '0) begin
			win_wr = CNT_BITS'(1);
		end else if (pwdata > APB_DATA_BITS'(MAX_WINDOW)) begin
			win_wr = CNT_BITS'(MAX_WINDOW);
		end else begin
			win_wr = pwdata[CNT_BITS-1:0];
		end
	end

	// position, fill and window size of the incoming transaction
	always_comb begin
		is_start = s_tuser[0] | (fill_q == '0);
		if (is_start) begin
			fill_new = CNT_BITS'(1);
			wp_new   = '0;
		end else begin
			fill_new = (fill_q == CNT_BITS'(MAX_WINDOW)) ? fill_q : fill_q + CNT_BITS'(1);
			wp_new   = wp_q + ADDR_BITS'(1);
		end
		n_new    = (fill_new < window_q) ? fill_new : window_q;
		is_ramp  = ({1'b0, n_q} + (CNT_BITS+1)'(1)) == {1'b0, n_new};
		is_slide = (n_new == n_q);
	end

	// read address: the dropped sample on a slide, else the rescan pointer
	assign raddr    = (state_q == ST_IDLE) ? (wp_new - n_new[ADDR_BITS-1:0]) : addr_q;
	assign scan_sum = sum_q + SUM_BITS'(rd_sample);

	// multiplier and divider launch
	always_comb begin
		mul_start    = 1'b0;
		mul_m        = n_q;
		mul_mcand    = MCAND_BITS'(smp_q);
		div_start    = 1'b0;
		div_divisor  = DIVR_BITS'(n_q);
		div_dividend = mode_q ? {wsum_q, FRAC_BITS'(0)}
		                      : {WSUM_BITS'(sum_q), FRAC_BITS'(0)};
		case (state_q)
			ST_IDLE: begin
				mul_start = accept & ~is_start & is_ramp;
				mul_m     = n_new;
				mul_mcand = MCAND_BITS'(in_sample);
			end
			ST_OLD: begin
				mul_start = 1'b1;
			end
			ST_PREP: begin
				mul_start = mode_q;
				mul_mcand = MCAND_BITS'({1'b0, n_q} + (CNT_BITS+1)'(1));
				div_start = ~mode_q;
			end
			ST_MUL: begin
				div_start   = mul_sts.done & tri_q;
				div_divisor = mul_prod[DIVR_BITS:1];
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// sequencer, sums and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= WINDOW_RESET;
			mode_q      <= 1'b0;
			fill_q      <= '0;
			wp_q        <= '0;
			n_q         <= '0;
			sum_q       <= '0;
			wsum_q      <= '0;
			left_q      <= '0;
			rd_valid_q  <= 1'b0;
			tri_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_WINDOW) begin
					window_q <= win_wr;
				end else begin
					mode_q <= pwdata[0];
				end
			end
			rd_valid_q <= (state_q == ST_SCAN) && (left_q != '0);
			// output register: load on completion, clear once taken
			if ((state_q == ST_DONE) && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q <= fill_new;
						wp_q   <= wp_new;
						n_q    <= n_new;
						tri_q  <= 1'b0;
						if (is_start) begin
							sum_q   <= SUM_BITS'(in_sample);
							wsum_q  <= WSUM_BITS'(in_sample);
							state_q <= ST_PREP;
						end else if (is_ramp) begin
							sum_q   <= sum_q + SUM_BITS'(in_sample);
							state_q <= ST_MUL;
						end else if (is_slide) begin
							state_q <= ST_OLD;
						end else begin
							sum_q   <= '0;
							wsum_q  <= '0;
							left_q  <= n_new;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_OLD: begin
					// oldest drops out, every remaining weight falls by one
					wsum_q  <= wsum_q - WSUM_BITS'(sum_q);
					sum_q   <= sum_q - SUM_BITS'(rd_sample) + SUM_BITS'(smp_q);
					state_q <= ST_MUL;
				end
				ST_SCAN: begin
					// newest first: each prefix sum adds once more to the weighted sum
					if (left_q != '0) begin
						left_q <= left_q - CNT_BITS'(1);
					end
					if (rd_valid_q) begin
						sum_q  <= scan_sum;
						wsum_q <= wsum_q + WSUM_BITS'(scan_sum);
					end
					if ((left_q == '0) && !rd_valid_q) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (mode_q) begin
						tri_q   <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_MUL: begin
					if (mul_sts.done) begin
						if (tri_q) begin
							state_q <= ST_DIV;
						end else begin
							wsum_q  <= wsum_q + WSUM_BITS'(mul_prod);
							state_q <= ST_PREP;
						end
					end
				end
				ST_DIV: begin
					if (div_sts.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q  <= in_sample;
			addr_q <= wp_new;
		end else if ((state_q == ST_SCAN) && (left_q != '0)) begin
			addr_q <= addr_q - ADDR_BITS'(1);
		end
		if ((state_q == ST_DONE) && (!out_valid_q || m_tready)) begin
			out_data_q <= div_quot;
		end
	end

	// delay line
	mavg_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WINDOW)
	) u_hist (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_new),
		.wdata (s_tdata),
		.raddr (raddr),
		.rdata (rd_data)
	);

	mavg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.m      (mul_m),
		.mcand  (mul_mcand),
		.sts    (mul_sts),
		.prod   (mul_prod)
	);

	mavg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.sts      (div_sts),
		.quotient (div_quot)
	);

	// checks
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_sts.busy && div_sts.busy))
		else $error("multiplier and divider busy together");

	a_window_size: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (n_q != '0) && (n_q <= fill_q))
		else $error("window size out of range after a transaction");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && (!out_valid_q || m_tready)) |=> m_tvalid)
		else $error("result not presented after completion");

endmodule

[sim/testbench.sv]
// testbench: self-checking bench for the moving average filter, plain and weighted modes
// predicts every average from its own copy of the delay line and configuration
// depends on mavg_pkg and moving_average_filter

module testbench;
	import mavg_pkg::*;

	localparam logic [APB_ADDR_BITS-1:0] ADDR_WINDOW = APB_ADDR_BITS'(4 * REG_WINDOW);
	localparam logic [APB_ADDR_BITS-1:0] ADDR_MODE   = APB_ADDR_BITS'(4 * REG_MODE);
	localparam int unsigned HOLD_AFTER  = 150;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned NUM_PHASES  = 8;

	// random phases: window as written, mode, sample count, idling
	localparam int unsigned PHASE_WINDOW [NUM_PHASES] = '{37, 1, 256, 0, 300, 7, 511, 16};
	localparam int unsigned PHASE_MODE   [NUM_PHASES] = '{1, 0, 1, 1, 0, 1, 1, 0};
	localparam int unsigned PHASE_ITEMS  [NUM_PHASES] = '{40, 40, 40, 40, 40, 40, 280, 40};
	localparam int unsigned PHASE_TX_IDLE[NUM_PHASES] = '{10, 10, 10, 62, 62, 62, 0, 0};
	localparam int unsigned PHASE_RX_IDLE[NUM_PHASES] = '{62, 62, 62, 10, 10, 10, 0, 0};

	// mirror of the filter and the averages still outstanding
	class average_scoreboard;
		logic signed [SAMPLE_BITS-1:0] delay_line [MAX_WINDOW];
		logic [ADDR_BITS-1:0] newest;
		int unsigned seen;
		int unsigned window;
		bit weighted;
		logic [OUT_BITS-1:0] expected_averages [$];
		int unsigned mismatches;

		function new();
			newest = '0;
			seen = 0;
			window = WINDOW_RESET;
			weighted = 1'b0;
			mismatches = 0;
			foreach (delay_line[i]) delay_line[i] = '0;
		endfunction

		// window is clamped into 1 .. MAX_WINDOW
		function void set_window(longint unsigned value);
			if (value < 1)
				window = 1;
			else if (value > MAX_WINDOW)
				window = MAX_WINDOW;
			else
				window = int'(value);
		endfunction

		function void set_mode(longint unsigned value);
			weighted = value[0];
		endfunction

		// accepted input transaction: store the sample and predict its average
		function void note_sample(logic signed [SAMPLE_BITS-1:0] smp, logic start);
			int unsigned n;
			int unsigned age;
			longint plain_sum;
			longint ramp_sum;
			longint quotient;
			if (start || seen == 0) begin
				seen = 0;
				newest = '0;
			end else begin
				newest = newest + 1'b1;
			end
			delay_line[newest] = smp;
			if (seen < MAX_WINDOW)
				seen++;
			n = (seen < window) ? seen : window;
			plain_sum = 0;
			ramp_sum = 0;
			// newest sample has weight n, the oldest weight 1
			for (age = 0; age < n; age++) begin
				plain_sum += longint'(delay_line[ADDR_BITS'(newest - age)]);
				ramp_sum += longint'(delay_line[ADDR_BITS'(newest - age)]) * longint'(n - age);
			end
			if (weighted)
				quotient = (ramp_sum * 256) / longint'(n * (n + 1) / 2);
			else
				quotient = (plain_sum * 256) / longint'(n);
			expected_averages.push_back(quotient[OUT_BITS-1:0]);
		endfunction

		// accepted output transaction against the oldest prediction
		function void check_average(logic [OUT_BITS-1:0] actual);
			logic [OUT_BITS-1:0] wanted;
			if (expected_averages.size() == 0) begin
				$display("%0t: unexpected average %0d", $time, $signed(actual));
				mismatches++;
			end else begin
				wanted = expected_averages.pop_front();
				if (actual !== wanted) begin
					$display("%0t: average mismatch, expected %0d actual %0d",
						$time, $signed(wanted), $signed(actual));
					mismatches++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [SAMPLE_BITS-1:0] s_tdata;   // [15:0] sample
	logic [0:0] s_tuser;               // [0] start_req
	logic m_tvalid;
	logic m_tready;
	logic [OUT_BITS-1:0] m_tdata;      // [23:0] average
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic pready;

	average_scoreboard sb = new();
	int unsigned samples_sent;
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;

	moving_average_filter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// output monitor
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_average(m_tdata);
	end

	// receiver: random stalls plus one long hold-off that backs up the block
	initial begin : receiver
		int unsigned hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!held && samples_sent >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// register write: setup then access, then the bus idles before the task returns
	task automatic write_reg(input logic [APB_ADDR_BITS-1:0] addr,
			input logic [APB_DATA_BITS-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_WINDOW)
			sb.set_window(data);
		else if (addr == ADDR_MODE)
			sb.set_mode(data);
		@(posedge clk);
	endtask

	// one input transaction, with random gaps in front
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic start);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_sample(smp, start);
		samples_sent++;
	endtask

	// hold the sender until every average has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_averages.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// full-scale values turn up often
	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(9))
			0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// vectors of random length, mostly short, a few longer than the largest window,
	// with the odd stray start request cutting one short
	task automatic run_phase(input int unsigned count, input bit one_vector);
		int unsigned left_in_vector;
		int unsigned k;
		logic start;
		left_in_vector = 0;
		for (k = 0; k < count; k++) begin
			if (one_vector) begin
				start = (k == 0);
			end else if (left_in_vector == 0) begin
				start = ($urandom_range(9) != 0);
				left_in_vector = ($urandom_range(9) == 0) ? $urandom_range(300, 40)
					: $urandom_range(30, 1);
			end else begin
				start = ($urandom_range(99) < 3);
			end
			if (left_in_vector != 0)
				left_in_vector--;
			send_sample(random_sample(), start);
		end
		wait_drained();
	endtask

	initial begin : stimulus
		int unsigned p;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		arst_n   <= 1'b0;
		samples_sent = 0;
		tx_idle_pct = 10;
		rx_idle_pct = 62;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration; first sample opens a vector without a start request
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(-16'sh8000, 1'b0);
		send_sample(-16'sh8000, 1'b1);
		send_sample(-16'sh0001, 1'b0);
		send_sample(16'sh0001, 1'b0);
		send_sample(16'sh0000, 1'b1);
		wait_drained();

		// window written as zero is held at one, weighted
		write_reg(ADDR_WINDOW, 32'd0);
		write_reg(ADDR_MODE, 32'd1);
		send_sample(-16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(-16'sh0001, 1'b1);
		wait_drained();

		// short weighted window
		write_reg(ADDR_WINDOW, 32'd2);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(-16'sh8000, 1'b0);
		send_sample(16'sd12345, 1'b0);
		send_sample(-16'sd7, 1'b1);
		send_sample(16'sd3, 1'b0);
		wait_drained();

		// oversized window is held at the maximum, plain mean
		write_reg(ADDR_WINDOW, 32'd511);
		write_reg(ADDR_MODE, 32'd0);
		send_sample(-16'sh8000, 1'b1);
		send_sample(-16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sd5, 1'b0);
		wait_drained();

		// random phases, one long vector fills and wraps the delay line
		for (p = 0; p < NUM_PHASES; p++) begin
			write_reg(ADDR_WINDOW, PHASE_WINDOW[p]);
			write_reg(ADDR_MODE, PHASE_MODE[p]);
			tx_idle_pct = PHASE_TX_IDLE[p];
			rx_idle_pct = PHASE_RX_IDLE[p];
			run_phase(PHASE_ITEMS[p], PHASE_ITEMS[p] > MAX_WINDOW);
		end

		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_averages.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#(12 * 2000000);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
